/* hw/rtl/ipv4c_pkg.sv */
package ipv4c_pkg;

	localparam int unsigned ADDR_W = 32;
	localparam int unsigned TAG_W = 3;
	localparam int unsigned HLEN_W = 6;
	localparam int unsigned PLEN_W = 16;

	localparam logic [ADDR_W-1:0] LOCAL_ADDRESS_RESET = '0;
	localparam logic FRAGMENT_ENABLE_RESET = 1'b1;

	typedef enum logic [3:0] {
		V_ICMP        = 4'd0,
		V_TCP         = 4'd1,
		V_UDP         = 4'd2,
		V_NOT_IPV4    = 4'd3,
		V_BAD_CSUM    = 4'd4,
		V_TTL_EXPIRED = 4'd5,
		V_NOT_OURS    = 4'd6,
		V_PROTO_UNRCH = 4'd7,
		V_FRAGMENT    = 4'd8
	} verdict_t;

	typedef struct packed {
		verdict_t          verdict;
		logic [ADDR_W-1:0] source_address;
		logic [7:0]        protocol;
		logic [HLEN_W-1:0] header_length;
		logic [PLEN_W-1:0] payload_length;
		logic [TAG_W-1:0]  buffer_id;
	} result_t;

endpackage

/* hw/rtl/ipv4c_parser.sv */
module ipv4c_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [7:0]                     header_byte,
	input  logic                           start_of_packet,
	input  logic [ipv4c_pkg::TAG_W-1:0]    buffer_id,
	input  logic [ipv4c_pkg::ADDR_W-1:0]   local_address,
	input  logic                           fragment_enable,
	output logic                           res_valid,
	output ipv4c_pkg::result_t             res
);
	import ipv4c_pkg::*;

	localparam logic [3:0] VER_IPV4 = 4'h4;
	localparam logic [3:0] VER_ALIAS = 4'h7;
	localparam logic [3:0] MIN_IHL = 4'd5;
	localparam logic [7:0] PROTO_ICMP = 8'h01;
	localparam logic [7:0] PROTO_TCP = 8'h06;
	localparam logic [7:0] PROTO_UDP = 8'h11;
	localparam logic [5:0] OFS_VERSION = 6'd0;
	localparam logic [5:0] OFS_TLEN_HI = 6'd2;
	localparam logic [5:0] OFS_TLEN_LO = 6'd3;
	localparam logic [5:0] OFS_FRAG_HI = 6'd6;
	localparam logic [5:0] OFS_FRAG_LO = 6'd7;
	localparam logic [5:0] OFS_TTL = 6'd8;
	localparam logic [5:0] OFS_PROTO = 6'd9;
	localparam logic [5:0] OFS_SRC_FIRST = 6'd12;
	localparam logic [5:0] OFS_SRC_LAST = 6'd15;
	localparam logic [5:0] OFS_DST_FIRST = 6'd16;
	localparam logic [5:0] OFS_DST_LAST = 6'd19;

	logic              skipping_q, skipping_n;
	logic [5:0]        byte_index_q, byte_index_n;
	logic [5:0]        ihl_bytes_q, ihl_bytes_n;
	logic [16:0]       sum_q, sum_n;
	logic [7:0]        high_q, high_n;
	logic [15:0]       total_q, total_n;
	logic [7:0]        ttl_q, ttl_n;
	logic [7:0]        proto_q, proto_n;
	logic [15:0]       frag_q, frag_n;
	logic [ADDR_W-1:0] src_q, src_n;
	logic [ADDR_W-1:0] dst_q, dst_n;
	logic [TAG_W-1:0]  tag_q, tag_n;

	logic [7:0]  hb;
	logic [5:0]  idx;
	logic        skip_eff;
	logic [16:0] sum_eff;
	logic [17:0] csum;
	logic        last;
	logic [15:0] ihl_ext;
	verdict_t    judged;

	always_comb begin
		skip_eff = start_of_packet ? 1'b0 : skipping_q;
		idx = start_of_packet ? OFS_VERSION : byte_index_q;
		sum_eff = start_of_packet ? 17'd0 : sum_q;
		hb = header_byte;
		if (idx == OFS_VERSION && header_byte[7:4] == VER_ALIAS) begin
			hb = {VER_IPV4, header_byte[3:0]};
		end

		skipping_n = skipping_q;
		byte_index_n = byte_index_q;
		ihl_bytes_n = ihl_bytes_q;
		sum_n = sum_q;
		high_n = high_q;
		total_n = total_q;
		ttl_n = ttl_q;
		proto_n = proto_q;
		frag_n = frag_q;
		src_n = src_q;
		dst_n = dst_q;
		tag_n = tag_q;
		csum = '0;
		last = 1'b0;
		res_valid = 1'b0;
		res = '0;

		if (step) begin
			if (start_of_packet) begin
				skipping_n = 1'b0;
				byte_index_n = '0;
				sum_n = '0;
				tag_n = buffer_id;
			end
			if (!skip_eff) begin
				if (idx == OFS_VERSION && (hb[7:4] != VER_IPV4 || hb[3:0] < MIN_IHL)) begin
					skipping_n = 1'b1;
					byte_index_n = '0;
					res_valid = 1'b1;
					res.verdict = V_NOT_IPV4;
					res.buffer_id = tag_n;
				end else begin
					if (idx == OFS_VERSION) begin
						ihl_bytes_n = {hb[3:0], 2'b00};
					end
					case (idx) inside
						OFS_TLEN_HI: total_n = {hb, total_q[7:0]};
						OFS_TLEN_LO: total_n = {total_q[15:8], hb};
						OFS_FRAG_HI: frag_n = {hb, frag_q[7:0]};
						OFS_FRAG_LO: frag_n = {frag_q[15:8], hb};
						OFS_TTL: ttl_n = hb;
						OFS_PROTO: proto_n = hb;
						[OFS_SRC_FIRST:OFS_SRC_LAST]: src_n = {src_q[ADDR_W-9:0], hb};
						[OFS_DST_FIRST:OFS_DST_LAST]: dst_n = {dst_q[ADDR_W-9:0], hb};
						default: ;
					endcase
					if (!idx[0]) begin
						high_n = hb;
					end else begin
						csum = {1'b0, sum_eff} + {2'b00, high_q, hb};
						if (csum[17:16] != 2'b00) begin
							csum = {2'b00, csum[15:0]} + 18'd1;
						end
						sum_n = csum[16:0];
					end
					last = ({1'b0, idx} + 7'd1) == {1'b0, ihl_bytes_n};
					if (last) begin
						skipping_n = 1'b1;
						byte_index_n = '0;
					end else begin
						byte_index_n = idx + 6'd1;
					end
				end
			end
		end

		if (sum_n != 17'h0ffff) begin
			judged = V_BAD_CSUM;
		end else if (ttl_n == 8'd0) begin
			judged = V_TTL_EXPIRED;
		end else if (dst_n != local_address) begin
			judged = V_NOT_OURS;
		end else if (fragment_enable && (frag_n[13] || frag_n[12:0] != 13'd0)) begin
			judged = V_FRAGMENT;
		end else begin
			case (proto_n)
				PROTO_ICMP: judged = V_ICMP;
				PROTO_TCP: judged = V_TCP;
				PROTO_UDP: judged = V_UDP;
				default: judged = V_PROTO_UNRCH;
			endcase
		end

		ihl_ext = {10'd0, ihl_bytes_n};
		if (last) begin
			res_valid = 1'b1;
			res.verdict = judged;
			res.source_address = src_n;
			res.protocol = proto_n;
			res.header_length = ihl_bytes_n;
			res.payload_length = (total_n >= ihl_ext) ? (total_n - ihl_ext) : '0;
			res.buffer_id = tag_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skipping_q <= 1'b1;
			byte_index_q <= '0;
		end else begin
			skipping_q <= skipping_n;
			byte_index_q <= byte_index_n;
		end
	end

	always_ff @(posedge clk) begin
		ihl_bytes_q <= ihl_bytes_n;
		sum_q <= sum_n;
		high_q <= high_n;
		total_q <= total_n;
		ttl_q <= ttl_n;
		proto_q <= proto_n;
		frag_q <= frag_n;
		src_q <= src_n;
		dst_q <= dst_n;
		tag_q <= tag_n;
	end

	a_index_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		!skipping_q |-> (byte_index_q < ihl_bytes_q || byte_index_q == 6'd0))
		else $error("Header byte index ran past the header length.");

	a_skip_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> skipping_q && byte_index_q == 6'd0)
		else $error("Parser did not return to waiting after a verdict.");

	a_result_only_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> step)
		else $error("Verdict produced without a header byte.");

endmodule

/* hw/rtl/ipv4_rx_header_classifier.sv */
// Path: an accepted header byte is registered in the input register and parsed, and the
// verdict it completes is registered into the output register, or the skid entry if that is held.
// Throughput: one header byte per cycle; input stalls while the output register, the skid
// entry and the input register together hold two or more entries not handed off this cycle.
// Reset: the parser waits for a start byte, no verdict is pending, local_address is
// zero and fragment_enable is one.
module ipv4_rx_header_classifier (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [0:0]                       cfg_index,
	input  logic [ipv4c_pkg::ADDR_W-1:0]     cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       header_byte,
	input  logic                             start_of_packet,
	input  logic [ipv4c_pkg::TAG_W-1:0]      buffer_id,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [3:0]                       verdict,
	output logic [ipv4c_pkg::ADDR_W-1:0]     source_address,
	output logic [7:0]                       protocol,
	output logic [ipv4c_pkg::HLEN_W-1:0]     header_length,
	output logic [ipv4c_pkg::PLEN_W-1:0]     payload_length,
	output logic [ipv4c_pkg::TAG_W-1:0]      result_buffer_id
);
	import ipv4c_pkg::*;

	localparam logic [0:0] REG_LOCAL_ADDRESS = 1'd0;
	localparam logic [0:0] REG_FRAGMENT_ENABLE = 1'd1;

	logic [ADDR_W-1:0] local_address_q;
	logic              fragment_enable_q;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             sop_s1;
	logic [TAG_W-1:0] tag_s1;

	logic    res_valid;
	result_t res;

	logic    out_valid_q, skid_valid_q;
	result_t out_q, skid_q;
	logic    pop;
	logic    accept;
	logic [1:0] occupancy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q <= LOCAL_ADDRESS_RESET;
			fragment_enable_q <= FRAGMENT_ENABLE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_LOCAL_ADDRESS: local_address_q <= cfg_data;
				REG_FRAGMENT_ENABLE: fragment_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign pop = out_valid_q && !out_stall;
	assign occupancy = {1'b0, out_valid_q} + {1'b0, skid_valid_q} + {1'b0, valid_s1};
	assign in_stall = (occupancy - {1'b0, pop}) > 2'd1;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= header_byte;
			sop_s1 <= start_of_packet;
			tag_s1 <= buffer_id;
		end
	end

	ipv4c_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (valid_s1),
		.header_byte     (byte_s1),
		.start_of_packet (sop_s1),
		.buffer_id       (tag_s1),
		.local_address   (local_address_q),
		.fragment_enable (fragment_enable_q),
		.res_valid       (res_valid),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= res_valid;
				end else begin
					out_valid_q <= res_valid;
				end
			end else if (!out_valid_q) begin
				out_valid_q <= res_valid;
			end else if (res_valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (!out_valid_q) begin
			out_q <= res;
		end else if (res_valid && !skid_valid_q) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign verdict = out_q.verdict;
	assign source_address = out_q.source_address;
	assign protocol = out_q.protocol;
	assign header_length = out_q.header_length;
	assign payload_length = out_q.payload_length;
	assign result_buffer_id = out_q.buffer_id;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("Skid entry holds a verdict while the output register is empty.");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && out_valid_q && skid_valid_q) |-> pop)
		else $error("Verdict arrived with no free result slot.");

	a_header_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.verdict != V_NOT_IPV4) |-> out_q.header_length >= 6'd20)
		else $error("Judged header shorter than the minimum IPv4 header.");

endmodule
